FILE: rtl/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg
// shared types and codes for the offset reorder buffer
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int LEN_BITS = 21;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NEG  = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_UNORDERED = 2'd0;
  localparam logic [1:0] REG_STREAMS   = 2'd1;
  localparam logic [1:0] REG_START     = 2'd2;
  localparam logic [1:0] REG_LIMIT     = 2'd3;

  // result source select
  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_END   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;     // capture the input request
    logic       decide;      // classify the captured request
    logic       hold;        // store the captured request in a free slot
    logic       advance_in;  // expected offset += captured length
    logic       release_hit; // free matched slot, advance, capture its entry
    logic       emit;        // load the output register
    logic [1:0] src;
    logic [1:0] kind;
    logic [1:0] err;
    logic       last;
    logic       stream_dec;
    logic       set_halt;
    logic       scan;        // register the match search
  } orb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic halted;
    logic finished;
    logic zero_len;
    logic unordered;
    logic neg;
    logic match;
    logic free_found;
    logic full_after;
    logic streams_one;
    logic hit;
  } orb_sts_t;

endpackage

FILE: rtl/orb_datapath.sv
// ----------------------------------------------------------------------------
// orb_datapath
// hold table, expected offset, stream count and output register
// ----------------------------------------------------------------------------
module orb_datapath #(
  parameter int HOLD_DEPTH  = 16,
  parameter int OFFSET_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_idx,
  input  logic [OFFSET_BITS-1:0]            cfg_data,
  input  logic [TAG_BITS-1:0]               in_buffer_tag,
  input  logic signed [OFFSET_BITS:0]       in_byte_offset,
  input  logic [orb_pkg::LEN_BITS-1:0]      in_byte_length,
  input  orb_pkg::orb_cmd_t                 cmd,
  output orb_pkg::orb_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [TAG_BITS-1:0]               out_tag,
  output logic signed [OFFSET_BITS:0]       out_offset,
  output logic [orb_pkg::LEN_BITS-1:0]      out_length,
  output logic [1:0]                        out_kind,
  output logic [1:0]                        error_code,
  output logic                              last_of_run
);

  localparam int IDX_BITS = $clog2(HOLD_DEPTH);
  localparam int CNT_BITS = $clog2(HOLD_DEPTH + 1);
  localparam int LEN_BITS = orb_pkg::LEN_BITS;

  // configuration
  logic                   unordered_r;
  logic [4:0]             limit_r;
  logic [OFFSET_BITS-1:0] expected_r;
  logic [7:0]             streams_left_r;
  logic                   halted_r;

  // captured request, or the held entry being released
  logic [TAG_BITS-1:0]    c_tag_r;
  logic [OFFSET_BITS:0]   c_off_r;
  logic [LEN_BITS-1:0]    c_len_r;

  // hold table
  logic [HOLD_DEPTH-1:0]  hv_r;
  logic [OFFSET_BITS-1:0] ho_r [HOLD_DEPTH];
  logic [LEN_BITS-1:0]    hl_r [HOLD_DEPTH];
  logic [TAG_BITS-1:0]    ht_r [HOLD_DEPTH];
  logic [CNT_BITS-1:0]    count_r;

  // registered search results
  logic                   hit_r;
  logic [IDX_BITS-1:0]    hit_idx_r;
  logic                   free_r;
  logic [IDX_BITS-1:0]    free_idx_r;
  logic                   match_r;
  logic                   full_r;

  logic                   hit_c, free_c;
  logic [IDX_BITS-1:0]    hit_idx_c, free_idx_c;
  logic [CNT_BITS-1:0]    limit_eff;

  // lowest matching and lowest free slot
  always_comb begin
    hit_c = 1'b0;
    hit_idx_c = '0;
    free_c = 1'b0;
    free_idx_c = '0;
    for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
      if (hv_r[i] && ho_r[i] == expected_r) begin
        hit_c = 1'b1;
        hit_idx_c = IDX_BITS'(i);
      end
      if (!hv_r[i]) begin
        free_c = 1'b1;
        free_idx_c = IDX_BITS'(i);
      end
    end
  end

  // effective limit clamped to 1..HOLD_DEPTH
  always_comb begin
    if (limit_r == 5'd0) begin
      limit_eff = CNT_BITS'(1);
    end else if (32'(limit_r) > HOLD_DEPTH) begin
      limit_eff = CNT_BITS'(HOLD_DEPTH);
    end else begin
      limit_eff = CNT_BITS'(limit_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unordered_r    <= 1'b0;
      limit_r        <= 5'd16;
      expected_r     <= '0;
      streams_left_r <= 8'd1;
      halted_r       <= 1'b0;
      hv_r           <= '0;
      count_r        <= '0;
      hit_r          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          orb_pkg::REG_UNORDERED: unordered_r <= cfg_data[0];
          orb_pkg::REG_STREAMS: streams_left_r <= cfg_data[7:0];
          orb_pkg::REG_START: expected_r <= cfg_data;
          orb_pkg::REG_LIMIT: limit_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.scan) begin
        hit_r <= hit_c;
      end
      if (cmd.stream_dec) begin
        streams_left_r <= streams_left_r - 8'd1;
      end
      if (cmd.set_halt) begin
        halted_r <= 1'b1;
      end
      if (cmd.advance_in) begin
        expected_r <= expected_r + OFFSET_BITS'(c_len_r);
      end
      if (cmd.hold) begin
        hv_r[free_idx_r] <= 1'b1;
        count_r <= count_r + CNT_BITS'(1);
      end
      if (cmd.release_hit) begin
        hv_r[hit_idx_r] <= 1'b0;
        count_r <= count_r - CNT_BITS'(1);
        expected_r <= expected_r + OFFSET_BITS'(hl_r[hit_idx_r]);
        hit_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      c_tag_r <= in_buffer_tag;
      c_off_r <= in_byte_offset;
      c_len_r <= in_byte_length;
    end else if (cmd.release_hit) begin
      c_tag_r <= ht_r[hit_idx_r];
      c_off_r <= {1'b0, ho_r[hit_idx_r]};
      c_len_r <= hl_r[hit_idx_r];
    end
    if (cmd.scan) begin
      hit_idx_r  <= hit_idx_c;
      free_r     <= free_c;
      free_idx_r <= free_idx_c;
    end
    if (cmd.decide) begin
      match_r <= (c_off_r[OFFSET_BITS-1:0] == expected_r);
      full_r  <= (count_r + CNT_BITS'(1)) >= limit_eff;
    end
    if (cmd.hold) begin
      ho_r[free_idx_r] <= c_off_r[OFFSET_BITS-1:0];
      hl_r[free_idx_r] <= c_len_r;
      ht_r[free_idx_r] <= c_tag_r;
    end
    if (cmd.emit) begin
      unique case (cmd.src)
        orb_pkg::SRC_END: begin
          out_tag    <= '0;
          out_offset <= {1'b0, expected_r};
          out_length <= '0;
        end
        default: begin
          out_tag    <= c_tag_r;
          out_offset <= c_off_r;
          out_length <= c_len_r;
        end
      endcase
      out_kind    <= cmd.kind;
      error_code  <= cmd.err;
      last_of_run <= cmd.last;
    end
  end

  // status to the controller
  always_comb begin
    sts.halted      = halted_r;
    sts.finished    = (streams_left_r == 8'd0);
    sts.zero_len    = (c_len_r == '0);
    sts.unordered   = unordered_r;
    sts.neg         = c_off_r[OFFSET_BITS];
    sts.match       = match_r;
    sts.free_found  = free_r;
    sts.full_after  = full_r;
    sts.streams_one = (streams_left_r == 8'd1);
    sts.hit         = hit_r;
  end

endmodule

FILE: rtl/orb_ctrl.sv
// ----------------------------------------------------------------------------
// orb_ctrl
// sequencer for accept, classify, hold and chained release
// ----------------------------------------------------------------------------
module orb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  orb_pkg::orb_sts_t sts,
  output orb_pkg::orb_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_CHAIN  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_free;

  // output register can take a new result
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      // search the table and register compares
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.decide = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.halted || sts.finished) begin
          state_nxt = ST_IDLE;
        end else if (sts.zero_len) begin
          if (!sts.streams_one) begin
            cmd.stream_dec = 1'b1;
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            cmd.stream_dec = 1'b1;
            cmd.emit = 1'b1;
            cmd.src  = orb_pkg::SRC_END;
            cmd.kind = orb_pkg::KIND_END;
            cmd.last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (sts.unordered) begin
          if (out_free) begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (sts.neg) begin
          if (out_free) begin
            cmd.emit = 1'b1;
            cmd.kind = orb_pkg::KIND_ERR;
            cmd.err  = orb_pkg::ERR_NEG;
            cmd.last = 1'b1;
            cmd.set_halt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (!sts.match) begin
          if (sts.free_found && !sts.full_after) begin
            cmd.hold = 1'b1;
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            cmd.hold = sts.free_found;
            cmd.emit = 1'b1;
            cmd.kind = orb_pkg::KIND_ERR;
            cmd.err  = orb_pkg::ERR_FULL;
            cmd.last = 1'b1;
            cmd.set_halt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          // in order: advance now, send once the next lookup is known
          cmd.advance_in = 1'b1;
          state_nxt = ST_CHAIN;
        end
      end
      // look up the next held entry at the new expected offset
      ST_CHAIN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_EMIT;
      end
      // send the pending release, last when nothing more matches
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = orb_pkg::SRC_INPUT;
          cmd.kind = orb_pkg::KIND_DATA;
          cmd.err  = orb_pkg::ERR_NONE;
          cmd.last = !sts.hit;
          if (sts.hit) begin
            cmd.release_hit = 1'b1;
            state_nxt = ST_CHAIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/orb_last.sv
// ----------------------------------------------------------------------------
// orb_last
// output register stage between the datapath and the result port
// ----------------------------------------------------------------------------
module orb_last #(
  parameter int OFFSET_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         a_valid,
  output logic                         a_ready,
  input  logic [TAG_BITS-1:0]          a_tag,
  input  logic signed [OFFSET_BITS:0]  a_offset,
  input  logic [orb_pkg::LEN_BITS-1:0] a_length,
  input  logic [1:0]                   a_kind,
  input  logic [1:0]                   a_err,
  input  logic                         a_last,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic signed [OFFSET_BITS:0]  out_offset,
  output logic [orb_pkg::LEN_BITS-1:0] out_length,
  output logic [1:0]                   out_kind,
  output logic [1:0]                   error_code,
  output logic                         last_of_run
);

  // one staged result, refilled as it leaves
  logic                         valid_r;
  logic [TAG_BITS-1:0]          t_r;
  logic [OFFSET_BITS:0]         o_r;
  logic [orb_pkg::LEN_BITS-1:0] l_r;
  logic [1:0]                   k_r, e_r;
  logic                         f_r;

  assign a_ready   = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (a_ready) begin
      valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      t_r <= a_tag;
      o_r <= a_offset;
      l_r <= a_length;
      k_r <= a_kind;
      e_r <= a_err;
      f_r <= a_last;
    end
  end

  assign out_tag     = t_r;
  assign out_offset  = o_r;
  assign out_length  = l_r;
  assign out_kind    = k_r;
  assign error_code  = e_r;
  assign last_of_run = f_r;

endmodule

FILE: rtl/offset_reorder_buffer_top.sv
// ----------------------------------------------------------------------------
// offset_reorder_buffer_top
// in-order release of buffer descriptors by byte offset
// ----------------------------------------------------------------------------
// One request is taken at a time. A request that is held, ignored, ends a
// stream, passes through in unordered mode or raises an error goes through
// the scan and decide states before the next one can be accepted. For one
// that matches the expected offset and releases held entries after it, each
// result waits for a registered lowest-match search of the hold table and is
// then sent, and the search that finds nothing marks the last result of the
// run. Every result passes two output registers, the datapath output register
// and then the orb_last stage, before the result port; while both are full
// the sequencer stalls and the input stays blocked.
module offset_reorder_buffer_top #(
  parameter int HOLD_DEPTH  = 16,
  parameter int OFFSET_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [OFFSET_BITS-1:0]       cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [TAG_BITS-1:0]          in_buffer_tag,
  input  logic signed [OFFSET_BITS:0]  in_byte_offset,
  input  logic [orb_pkg::LEN_BITS-1:0] in_byte_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic signed [OFFSET_BITS:0]  out_offset,
  output logic [orb_pkg::LEN_BITS-1:0] out_length,
  output logic [1:0]                   out_kind,
  output logic [1:0]                   out_error_code,
  output logic                         out_last_of_run
);

  orb_pkg::orb_cmd_t cmd;
  orb_pkg::orb_sts_t sts;

  logic                         s_valid, s_ready;
  logic [TAG_BITS-1:0]          s_tag;
  logic signed [OFFSET_BITS:0]  s_off;
  logic [orb_pkg::LEN_BITS-1:0] s_len;
  logic [1:0]                   s_kind, s_err;
  logic                         s_last;

  orb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  orb_datapath #(
    .HOLD_DEPTH  (HOLD_DEPTH),
    .OFFSET_BITS (OFFSET_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_buffer_tag  (in_buffer_tag),
    .in_byte_offset (in_byte_offset),
    .in_byte_length (in_byte_length),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (s_ready),
    .out_valid      (s_valid),
    .out_tag        (s_tag),
    .out_offset     (s_off),
    .out_length     (s_len),
    .out_kind       (s_kind),
    .error_code     (s_err),
    .last_of_run    (s_last)
  );

  orb_last #(
    .OFFSET_BITS (OFFSET_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_last (
    .clk         (clk),
    .rst_n       (rst_n),
    .a_valid     (s_valid),
    .a_ready     (s_ready),
    .a_tag       (s_tag),
    .a_offset    (s_off),
    .a_length    (s_len),
    .a_kind      (s_kind),
    .a_err       (s_err),
    .a_last      (s_last),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_tag     (out_tag),
    .out_offset  (out_offset),
    .out_length  (out_length),
    .out_kind    (out_kind),
    .error_code  (out_error_code),
    .last_of_run (out_last_of_run)
  );

endmodule
